@@ rtl/core/omre_pkg.sv @@
package omre_pkg;

	// field widths
	localparam int KEY_W  = 32;
	localparam int RANK_W = 11;
	localparam int MODE_W = 3;

	// default store depth
	localparam int CAPACITY_DEF = 1024;

	// command codes
	localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_DELETE = 3'd1;
	localparam logic [MODE_W-1:0] MODE_RANK   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SELECT = 3'd3;
	localparam logic [MODE_W-1:0] MODE_PRED   = 3'd4;
	localparam logic [MODE_W-1:0] MODE_SUCC   = 3'd5;

	// control handed to every cell
	typedef struct packed {
		logic cmp_en;
		logic ins_en;
		logic del_en;
	} cell_ctl_t;

	// per-cell contribution to the reduction
	typedef struct packed {
		logic             found;
		logic             first_ge;
		logic [KEY_W-1:0] pred;
		logic [KEY_W-1:0] succ;
		logic [KEY_W-1:0] sel;
	} cell_out_t;

	// reduced answers
	typedef struct packed {
		logic             found;
		logic [KEY_W-1:0] pred;
		logic [KEY_W-1:0] succ;
		logic [KEY_W-1:0] sel;
	} red_t;

endpackage

@@ rtl/core/omre_cell.sv @@
module omre_cell #(
	parameter int CAPACITY = omre_pkg::CAPACITY_DEF,
	parameter int IDX      = 0
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  omre_pkg::cell_ctl_t             ctl,
	input  logic signed [omre_pkg::KEY_W-1:0] cmd_key,
	input  logic [omre_pkg::RANK_W-1:0]     cmd_rank,
	input  logic [$clog2(CAPACITY+1)-1:0]   count,
	input  logic signed [omre_pkg::KEY_W-1:0] left_key,
	input  logic                            left_gt,
	input  logic                            left_ge,
	input  logic signed [omre_pkg::KEY_W-1:0] right_key,
	input  logic                            right_ge,
	output logic signed [omre_pkg::KEY_W-1:0] key,
	output logic                            gt,
	output logic                            ge,
	output omre_pkg::cell_out_t             co
);

	localparam int CNT_W = $clog2(CAPACITY+1);

	logic signed [omre_pkg::KEY_W-1:0] key_q;
	logic gt_q, ge_q, eq_q, sel_q, vld_q;
	logic valid;
	logic first_ge, first_gt, last_lt;

	// occupied when below the fill count
	assign valid = count > CNT_W'(IDX);

	// compare flags, empty cells count as above every key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gt_q  <= 1'b0;
			ge_q  <= 1'b0;
			eq_q  <= 1'b0;
			sel_q <= 1'b0;
			vld_q <= 1'b0;
		end else if (ctl.cmp_en) begin
			gt_q  <= !valid || (key_q > cmd_key);
			ge_q  <= !valid || (key_q >= cmd_key);
			eq_q  <= valid && (key_q == cmd_key);
			sel_q <= valid && (32'(cmd_rank) == 32'(IDX + 1));
			vld_q <= valid;
		end
	end

	// key storage: shift right on insert, shift left on delete
	always_ff @(posedge clk) begin
		if (ctl.ins_en) begin
			if (left_gt)
				key_q <= left_key;
			else if (gt_q)
				key_q <= cmd_key;
		end else if (ctl.del_en) begin
			if (ge_q)
				key_q <= right_key;
		end
	end

	// boundary detection against the neighbors
	assign first_ge = ge_q && !left_ge;
	assign first_gt = gt_q && !left_gt && vld_q;
	assign last_lt  = !ge_q && right_ge;

	assign co.found    = first_ge && eq_q;
	assign co.first_ge = first_ge;
	assign co.pred     = last_lt  ? key_q : '0;
	assign co.succ     = first_gt ? key_q : '0;
	assign co.sel      = sel_q    ? key_q : '0;

	assign key = key_q;
	assign gt  = gt_q;
	assign ge  = ge_q;

endmodule

@@ rtl/core/omre_reduce.sv @@
module omre_reduce #(
	parameter int CAPACITY = omre_pkg::CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          en,
	input  omre_pkg::cell_out_t           co [CAPACITY],
	output omre_pkg::red_t                red_q,
	output logic [$clog2(CAPACITY+1)-1:0] pos_q
);

	localparam int CNT_W = $clog2(CAPACITY+1);
	localparam int IDX_W = $clog2(CAPACITY);

	omre_pkg::red_t    red_d;
	logic [IDX_W-1:0]  enc;
	logic              any_ge;

	// OR across cells; at most one cell drives each term
	always_comb begin
		red_d  = '0;
		enc    = '0;
		any_ge = 1'b0;
		for (int i = 0; i < CAPACITY; i++) begin
			red_d.found = red_d.found | co[i].found;
			red_d.pred  = red_d.pred  | co[i].pred;
			red_d.succ  = red_d.succ  | co[i].succ;
			red_d.sel   = red_d.sel   | co[i].sel;
			any_ge      = any_ge | co[i].first_ge;
			enc         = enc | (co[i].first_ge ? IDX_W'(i) : '0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red_q <= red_d;
			pos_q <= any_ge ? CNT_W'(enc) : CNT_W'(CAPACITY);
		end
	end

endmodule

@@ rtl/core/ordered_multiset_rank_engine_top.sv @@
// Ordered multiset of signed 32-bit keys with rank and order queries.
// Input stream s_*: one command item per handshake. s_tuser carries the
// command, s_tdata carries the key and the 1-based rank for select.
// Output stream m_*: one answer item per query command; insert, delete
// and the unused command codes give no item.
// The keys live in a chain of cells kept sorted. A command takes three
// steps: compare in every cell, OR reduction across the chain, then
// update (insert/delete shift one place) or load of the output register.
// The next item is taken in that third step, so the block takes no new
// item before it is through with the last; a query answer is registered
// in the third step. The three-step cell/reduction sequence sets this.
// When the receiver stalls, the answer waits in the output register; a
// following query holds in its last step until the register frees,
// an insert or delete does not wait.
// Reset empties the store (fill count zero), clears the output valid and
// returns to idle with s_tready high; no clearing pass is needed.
module ordered_multiset_rank_engine_top #(
	parameter int CAPACITY = omre_pkg::CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // [31:0] key, [42:32] rank_query, rest zero
	input  logic [2:0]  s_tuser,   // [2:0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // [31:0] answer
);

	localparam int CNT_W = $clog2(CAPACITY+1);
	localparam int KW    = omre_pkg::KEY_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_RED,
		ST_FIN
	} state_t;

	state_t state_q;

	logic [omre_pkg::MODE_W-1:0] mode_q;
	logic signed [KW-1:0]        key_q;
	logic [omre_pkg::RANK_W-1:0] rank_q;
	logic [CNT_W-1:0]            count_q;
	logic                        m_tvalid_q;
	logic [KW-1:0]               m_tdata_q;

	omre_pkg::cell_ctl_t ctl;
	omre_pkg::cell_out_t co [CAPACITY];
	omre_pkg::red_t      red_q;
	logic [CNT_W-1:0]    pos_q;

	logic signed [KW-1:0] key_w [CAPACITY];
	logic                 gt_w  [CAPACITY];
	logic                 ge_w  [CAPACITY];

	logic s_acc, is_query, out_free, fin_go, full;
	logic [KW-1:0] answer;

	assign full     = count_q == CNT_W'(CAPACITY);
	assign is_query = (mode_q == omre_pkg::MODE_RANK) || (mode_q == omre_pkg::MODE_SELECT) ||
	                  (mode_q == omre_pkg::MODE_PRED) || (mode_q == omre_pkg::MODE_SUCC);
	assign out_free = !m_tvalid_q || m_tready;
	assign fin_go   = (state_q == ST_FIN) && (!is_query || out_free);
	assign s_tready = (state_q == ST_IDLE) || fin_go;
	assign s_acc    = s_tvalid && s_tready;

	// cell control
	assign ctl.cmp_en = state_q == ST_CMP;
	assign ctl.ins_en = fin_go && (mode_q == omre_pkg::MODE_INSERT) && !full;
	assign ctl.del_en = fin_go && (mode_q == omre_pkg::MODE_DELETE) && red_q.found;

	// answer select
	always_comb begin
		case (mode_q)
			omre_pkg::MODE_RANK:   answer = KW'(pos_q) + KW'(1);
			omre_pkg::MODE_SELECT: answer = red_q.sel;
			omre_pkg::MODE_PRED:   answer = red_q.pred;
			omre_pkg::MODE_SUCC:   answer = red_q.succ;
			default:               answer = '0;
		endcase
	end

	// sequencer, fill count and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tready)
				m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_acc)
						state_q <= ST_CMP;
				end
				ST_CMP: state_q <= ST_RED;
				ST_RED: state_q <= ST_FIN;
				ST_FIN: begin
					if (fin_go) begin
						state_q <= s_acc ? ST_CMP : ST_IDLE;
						if (is_query)
							m_tvalid_q <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (ctl.ins_en)
				count_q <= count_q + CNT_W'(1);
			else if (ctl.del_en)
				count_q <= count_q - CNT_W'(1);
		end
	end

	// command and answer payload
	always_ff @(posedge clk) begin
		if (s_acc) begin
			mode_q <= s_tuser;
			key_q  <= s_tdata[31:0];
			rank_q <= s_tdata[42:32];
		end
		if (fin_go && is_query)
			m_tdata_q <= answer;
	end

	// cell chain
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam int LEFT  = (i == 0) ? 0 : i - 1;
		localparam int RIGHT = (i == CAPACITY - 1) ? i : i + 1;

		logic signed [KW-1:0] lk, rk;
		logic lgt, lge, rge;

		assign lk  = key_w[LEFT];
		assign lgt = (i == 0) ? 1'b0 : gt_w[LEFT];
		assign lge = (i == 0) ? 1'b0 : ge_w[LEFT];
		assign rk  = key_w[RIGHT];
		assign rge = (i == CAPACITY - 1) ? 1'b1 : ge_w[RIGHT];

		omre_cell #(
			.CAPACITY(CAPACITY),
			.IDX     (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.cmd_key  (key_q),
			.cmd_rank (rank_q),
			.count    (count_q),
			.left_key (lk),
			.left_gt  (lgt),
			.left_ge  (lge),
			.right_key(rk),
			.right_ge (rge),
			.key      (key_w[i]),
			.gt       (gt_w[i]),
			.ge       (ge_w[i]),
			.co       (co[i])
		);
	end

	omre_reduce #(
		.CAPACITY(CAPACITY)
	) u_reduce (
		.clk  (clk),
		.en   (state_q == ST_RED),
		.co   (co),
		.red_q(red_q),
		.pos_q(pos_q)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

@@ rtl/core/omre_checker.sv @@
module omre_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	// stalled answer holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("answer changed while stalled");

	// one command at a time: input closed through the compare and reduction steps after each accept
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
		else $error("item accepted during command processing");

	// a fresh answer follows its item through the compare, reduction and
	// final steps, with the valid registered at the end of the final step
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 4))
		else $error("answer without matching item");

endmodule

bind ordered_multiset_rank_engine_top omre_checker u_omre_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

	typedef logic [omre_pkg::MODE_W-1:0]       mode_t;
	typedef logic [omre_pkg::RANK_W-1:0]       rank_t;
	typedef logic signed [omre_pkg::KEY_W-1:0] key_t;

	// store depth as the block is built by default
	localparam int STORE_DEPTH = omre_pkg::CAPACITY_DEF;
	localparam int N_RANDOM    = 650;
	localparam int LONG_HOLD   = 300;
	localparam int DRAIN_WAIT  = 80;
	localparam int N_DIRECTED  = 25;

	// command codes the block ignores
	localparam mode_t MODE_SPARE_6 = 3'd6;
	localparam mode_t MODE_SPARE_7 = 3'd7;

	localparam key_t KEY_MIN = 32'sh8000_0000;
	localparam key_t KEY_MAX = 32'sh7FFF_FFFF;

	typedef struct packed {
		mode_t mode;
		key_t  key;
		rank_t rank;
		logic  fixed;
		key_t  answer;
	} cmd_row_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [47:0]                  s_tdata = '0;
	mode_t                        s_tuser = '0;
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	logic [omre_pkg::KEY_W-1:0]   m_tdata;

	// shadow copy of the multiset
	key_t store_keys [STORE_DEPTH];
	int   fill_level = 0;
	key_t answers_due [$];

	int error_count   = 0;
	int answers_seen  = 0;
	int inserts_sent  = 0;
	int deletes_sent  = 0;
	int queries_sent  = 0;
	int dropped_ins   = 0;
	bit quiet         = 1'b0;
	bit hold_req      = 1'b0;

	ordered_multiset_rank_engine_top #(
		.CAPACITY(STORE_DEPTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always #5 clk = ~clk;

	// directed commands; answers typed in where obvious, else predicted
	cmd_row_t directed_rows [N_DIRECTED] = '{
		'{omre_pkg::MODE_RANK,    32'sd5,  11'd0,    1'b1, 32'sd1},
		'{omre_pkg::MODE_SELECT,  32'sd0,  11'd1,    1'b1, 32'sd0},
		'{omre_pkg::MODE_PRED,    32'sd0,  11'd0,    1'b1, 32'sd0},
		'{omre_pkg::MODE_SUCC,    32'sd0,  11'd0,    1'b1, 32'sd0},
		'{omre_pkg::MODE_DELETE,  32'sd7,  11'd0,    1'b0, 32'sd0},
		'{omre_pkg::MODE_INSERT,  KEY_MIN, 11'd0,    1'b0, 32'sd0},
		'{omre_pkg::MODE_INSERT,  KEY_MAX, 11'd0,    1'b0, 32'sd0},
		'{omre_pkg::MODE_INSERT,  32'sd0,  11'd0,    1'b0, 32'sd0},
		'{omre_pkg::MODE_INSERT,  32'sd0,  11'd0,    1'b0, 32'sd0},
		'{omre_pkg::MODE_INSERT,  -32'sd1, 11'd0,    1'b0, 32'sd0},
		'{omre_pkg::MODE_RANK,    KEY_MAX, 11'd0,    1'b1, 32'sd5},
		'{omre_pkg::MODE_RANK,    KEY_MIN, 11'd0,    1'b1, 32'sd1},
		'{omre_pkg::MODE_PRED,    KEY_MIN, 11'd0,    1'b1, 32'sd0},
		'{omre_pkg::MODE_SUCC,    KEY_MAX, 11'd0,    1'b1, 32'sd0},
		'{omre_pkg::MODE_SELECT,  32'sd0,  11'd1,    1'b1, KEY_MIN},
		'{omre_pkg::MODE_SELECT,  32'sd0,  11'd5,    1'b1, KEY_MAX},
		'{omre_pkg::MODE_SELECT,  32'sd0,  11'd0,    1'b1, 32'sd0},
		'{omre_pkg::MODE_SELECT,  32'sd0,  11'd6,    1'b1, 32'sd0},
		'{omre_pkg::MODE_SELECT,  32'sd0,  11'd1025, 1'b1, 32'sd0},
		'{omre_pkg::MODE_PRED,    32'sd0,  11'd0,    1'b0, 32'sd0},
		'{omre_pkg::MODE_SUCC,    32'sd0,  11'd0,    1'b0, 32'sd0},
		'{omre_pkg::MODE_DELETE,  32'sd0,  11'd0,    1'b0, 32'sd0},
		'{omre_pkg::MODE_RANK,    KEY_MAX - 32'sd1, 11'd0, 1'b0, 32'sd0},
		'{MODE_SPARE_6,           -32'sd1, 11'd1024, 1'b0, 32'sd0},
		'{MODE_SPARE_7,           KEY_MIN, 11'd1025, 1'b0, 32'sd0}
	};

	// stored keys strictly below k
	function automatic int keys_below(input key_t k);
		int n;
		n = 0;
		for (int i = 0; i < fill_level; i++)
			if (store_keys[i] < k) n++;
		return n;
	endfunction

	// stored keys not above k
	function automatic int keys_not_above(input key_t k);
		int n;
		n = 0;
		for (int i = 0; i < fill_level; i++)
			if (store_keys[i] <= k) n++;
		return n;
	endfunction

	// apply one command to the shadow multiset; returns 1 when an answer is due
	function automatic bit multiset_step(input mode_t mode, input key_t k,
			input rank_t rq, output key_t ans);
		int pos;
		ans = '0;
		case (mode)
			omre_pkg::MODE_INSERT: begin
				if (fill_level >= STORE_DEPTH) begin
					dropped_ins++;
				end else begin
					pos = keys_not_above(k);
					for (int i = fill_level; i > pos; i--)
						store_keys[i] = store_keys[i-1];
					store_keys[pos] = k;
					fill_level++;
				end
				return 1'b0;
			end
			omre_pkg::MODE_DELETE: begin
				pos = keys_below(k);
				if (pos < fill_level && store_keys[pos] == k) begin
					for (int i = pos; i < fill_level - 1; i++)
						store_keys[i] = store_keys[i+1];
					fill_level--;
				end
				return 1'b0;
			end
			omre_pkg::MODE_RANK: begin
				ans = key_t'(keys_below(k) + 1);
				return 1'b1;
			end
			omre_pkg::MODE_SELECT: begin
				if (rq >= 1 && int'(rq) <= fill_level) ans = store_keys[rq-1];
				return 1'b1;
			end
			omre_pkg::MODE_PRED: begin
				pos = keys_below(k);
				if (pos > 0) ans = store_keys[pos-1];
				return 1'b1;
			end
			omre_pkg::MODE_SUCC: begin
				pos = keys_not_above(k);
				if (pos < fill_level) ans = store_keys[pos];
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	task automatic report(input string what, input key_t got, input key_t want);
		$display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
		error_count++;
	endtask

	task automatic check_answer(input key_t got);
		key_t want;
		answers_seen++;
		if (answers_due.size() == 0) begin
			report("answer with none pending", got, '0);
		end else begin
			want = answers_due.pop_front();
			if (got !== want) report("answer", got, want);
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic key_t pick_key();
		int r;
		r = $urandom_range(0, 9);
		if (r <= 4) return key_t'(int'($urandom_range(0, 16)) - 8);
		if (r <= 6 && fill_level > 0) return store_keys[$urandom_range(0, fill_level - 1)];
		if (r == 7) begin
			case ($urandom_range(0, 3))
				0: return KEY_MIN;
				1: return KEY_MAX;
				2: return KEY_MIN + 32'sd1;
				default: return KEY_MAX - 32'sd1;
			endcase
		end
		return key_t'($urandom);
	endfunction

	function automatic rank_t pick_rank();
		int r;
		r = $urandom_range(0, 9);
		if (r <= 6) return rank_t'($urandom_range(0, fill_level + 1));
		if (r <= 8) return rank_t'($urandom_range(0, 1025));
		return rank_t'($urandom_range(1024, 1025));
	endfunction

	function automatic mode_t pick_mode(input int ins_weight);
		int r;
		r = $urandom_range(0, 99);
		if (r < 2) return ($urandom_range(0, 1) == 0) ? MODE_SPARE_6 : MODE_SPARE_7;
		if (r < 2 + ins_weight) return omre_pkg::MODE_INSERT;
		if (r < 17 + ins_weight) return omre_pkg::MODE_DELETE;
		case ($urandom_range(0, 3))
			0: return omre_pkg::MODE_RANK;
			1: return omre_pkg::MODE_SELECT;
			2: return omre_pkg::MODE_PRED;
			default: return omre_pkg::MODE_SUCC;
		endcase
	endfunction

	// offer one item, wait for it to be taken, then record what it should give
	task automatic send_cmd(input mode_t mode, input key_t k,
			input rank_t rq, input bit fixed, input key_t fixed_ans);
		key_t ans;
		bit   has_ans;
		int   gap;
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {5'b0, rq, k};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		has_ans = multiset_step(mode, k, rq, ans);
		if (has_ans) begin
			answers_due.push_back(fixed ? fixed_ans : ans);
			queries_sent++;
		end else if (mode == omre_pkg::MODE_INSERT) begin
			inserts_sent++;
		end else if (mode == omre_pkg::MODE_DELETE) begin
			deletes_sent++;
		end
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// result side: check every accepted answer, stall at random
	initial begin
		int stall_left;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) check_answer(key_t'(m_tdata));
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (hold_req) begin
				// long hold-off so the block backs up and stalls its input
				hold_req = 1'b0;
				stall_left = LONG_HOLD - 1;
				m_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 99) < 30) begin
				stall_left = pick_gap();
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// stimulus and end of run
	initial begin
		int sent;
		int ins_weight;
		mode_t mode;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			send_cmd(directed_rows[i].mode, directed_rows[i].key, directed_rows[i].rank,
				directed_rows[i].fixed, directed_rows[i].answer);

		sent = 0;
		ins_weight = 80;
		while (sent < N_RANDOM) begin
			if (sent % 60 == 0 && sent > 0) begin
				case ($urandom_range(0, 2))
					0: ins_weight = 80;
					1: ins_weight = 45;
					default: ins_weight = 15;
				endcase
				quiet = ($urandom_range(0, 4) == 0);
			end
			if (sent == 150) hold_req = 1'b1;
			// sender pause until every answer has come back
			if (sent == 400) begin
				s_tvalid <= 1'b0;
				while (answers_due.size() != 0) @(posedge clk);
				@(posedge clk);
			end
			mode = pick_mode(ins_weight);
			send_cmd(mode, pick_key(), pick_rank(), 1'b0, '0);
			if (mode != MODE_SPARE_6 && mode != MODE_SPARE_7) sent++;
		end

		s_tvalid <= 1'b0;
		while (answers_due.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Covered %0d inserts (%0d dropped on a full store), %0d deletes, %0d queries;",
			inserts_sent, dropped_ins, deletes_sent, queries_sent);
		$display("%0d answers compared, %0d mismatches.", answers_seen, error_count);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// watchdog
	initial begin
		#5ms;
		$display("Timeout with %0d answers still pending", answers_due.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ ordered_multiset_rank_engine_top.f @@
rtl/core/omre_pkg.sv
rtl/core/omre_cell.sv
rtl/core/omre_reduce.sv
rtl/core/ordered_multiset_rank_engine_top.sv
rtl/core/omre_checker.sv
tb/tb_top.sv
